@@ design/esd_pkg.sv @@
// shared types, character codes and helpers for the escape sequence decoder
package esd_pkg;

	localparam int CHAR_W     = 16;
	localparam int CHAR_BITS  = 16;
	localparam int RES_DEPTH  = 5;
	localparam int RES_CNT_W  = 3;
	localparam int HOLD_DEPTH = 3;
	localparam int HOLD_W     = 7;

	localparam logic [CHAR_W-1:0] CHAR_MASK = (CHAR_BITS >= CHAR_W) ? {CHAR_W{1'b1}} :
		CHAR_W'((64'd1 << CHAR_BITS) - 64'd1);

	// character codes
	localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_THREE  = 16'h0033;
	localparam logic [CHAR_W-1:0] CH_SEVEN  = 16'h0037;
	localparam logic [CHAR_W-1:0] CH_X      = 16'h0078;
	localparam logic [CHAR_W-1:0] CH_U      = 16'h0075;
	localparam logic [CHAR_W-1:0] CH_A      = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_B      = 16'h0062;
	localparam logic [CHAR_W-1:0] CH_F      = 16'h0066;
	localparam logic [CHAR_W-1:0] CH_N      = 16'h006E;
	localparam logic [CHAR_W-1:0] CH_R      = 16'h0072;
	localparam logic [CHAR_W-1:0] CH_T      = 16'h0074;
	localparam logic [CHAR_W-1:0] CH_V      = 16'h0076;
	localparam logic [CHAR_W-1:0] CODE_BEL  = 16'h0007;
	localparam logic [CHAR_W-1:0] CODE_BS   = 16'h0008;
	localparam logic [CHAR_W-1:0] CODE_FF   = 16'h000C;
	localparam logic [CHAR_W-1:0] CODE_LF   = 16'h000A;
	localparam logic [CHAR_W-1:0] CODE_CR   = 16'h000D;
	localparam logic [CHAR_W-1:0] CODE_HT   = 16'h0009;
	localparam logic [CHAR_W-1:0] CODE_VT   = 16'h000B;

	// escape phase of the decoder
	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_BS   = 7'b0000010,
		PH_OCT0 = 7'b0000100,
		PH_OCT1 = 7'b0001000,
		PH_OCT2 = 7'b0010000,
		PH_HEX  = 7'b0100000,
		PH_UNI  = 7'b1000000
	} phase_t;

	// beat controller state
	typedef enum logic [1:0] {
		C_IDLE = 2'b01,
		C_SEND = 2'b10
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic pop;
	} esd_cmd_t;

	typedef struct packed {
		logic load_has_res;
		logic one_left;
	} esd_stat_t;

	typedef logic [RES_DEPTH-1:0][CHAR_W-1:0] res_list_t;

	// {valid, nibble} of a hex digit character
	function automatic logic [4:0] hex_val(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 16'h0030 && c <= 16'h0039) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

@@ design/esd_ctrl.sv @@
// beat controller: accepts one input beat, then drains its results
module esd_ctrl import esd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_valid,
	output logic      s_ready,
	output logic      m_valid,
	input  logic      m_ready,
	input  esd_stat_t stat,
	output esd_cmd_t  cmd
);

	ctrl_state_t state_q, state_nx;

	assign s_ready  = (state_q == C_IDLE);
	assign m_valid  = (state_q == C_SEND);
	assign cmd.load = s_valid & s_ready;
	assign cmd.pop  = m_valid & m_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			C_IDLE: begin
				if (cmd.load && stat.load_has_res) state_nx = C_SEND;
			end
			C_SEND: begin
				if (cmd.pop && stat.one_left) state_nx = C_IDLE;
			end
			default: state_nx = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= C_IDLE;
		else state_q <= state_nx;
	end

endmodule

@@ design/esd_dp.sv @@
// decode datapath: escape phase, held digits, partial value and result buffer
module esd_dp import esd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  esd_cmd_t          cmd,
	input  logic [CHAR_W-1:0] in_char,
	input  logic              in_last,
	output esd_stat_t         stat,
	output logic [CHAR_W-1:0] out_char,
	output logic              run_last,
	output logic              text_end
);

	phase_t                    ph_q, ph_n;
	logic [CHAR_W-1:0]         pv_q, pv_n;
	logic [1:0]                hc_q, hc_n;
	logic [HOLD_W-1:0]         held_q [HOLD_DEPTH];
	logic [HOLD_W-1:0]         held_n [HOLD_DEPTH];
	res_list_t                 buf_q, lst;
	logic [RES_CNT_W-1:0]      cnt_q, n;
	logic                      end_q;
	logic [CHAR_W-1:0]         c, pv_oct, pv_hex, letter, f_letter;
	logic [4:0]                hv;
	logic                      fresh, need_done;

	assign c      = in_char & CHAR_MASK;
	assign hv     = hex_val(c);
	assign pv_oct = {pv_q[CHAR_W-4:0], c[2:0]};
	assign pv_hex = {pv_q[CHAR_W-5:0], hv[3:0]};
	assign letter = (ph_q == PH_UNI) ? CH_U : CH_X;
	assign need_done = (ph_q == PH_UNI) ? (hc_q == 2'd3) : (hc_q == 2'd1);

	always_comb begin
		lst      = '0;
		n        = '0;
		ph_n     = ph_q;
		pv_n     = pv_q;
		hc_n     = hc_q;
		held_n   = held_q;
		fresh    = 1'b0;
		f_letter = CH_X;
		case (ph_q)
			PH_BS: begin
				ph_n = PH_IDLE;
				pv_n = '0;
				hc_n = '0;
				case (c)
					CH_ZERO: ph_n = PH_OCT0;
					CH_X:    ph_n = PH_HEX;
					CH_U:    ph_n = PH_UNI;
					CH_A: begin lst[n] = CODE_BEL; n = n + 3'd1; end
					CH_B: begin lst[n] = CODE_BS;  n = n + 3'd1; end
					CH_F: begin lst[n] = CODE_FF;  n = n + 3'd1; end
					CH_N: begin lst[n] = CODE_LF;  n = n + 3'd1; end
					CH_R: begin lst[n] = CODE_CR;  n = n + 3'd1; end
					CH_T: begin lst[n] = CODE_HT;  n = n + 3'd1; end
					CH_V: begin lst[n] = CODE_VT;  n = n + 3'd1; end
					default: begin lst[n] = c; n = n + 3'd1; end
				endcase
			end
			PH_OCT0: begin
				if (c >= CH_ZERO && c <= CH_THREE) begin
					pv_n = {{(CHAR_W-2){1'b0}}, c[1:0]};
					ph_n = PH_OCT1;
				end else begin
					lst[n] = '0;
					n      = n + 3'd1;
					pv_n   = '0;
					ph_n   = PH_IDLE;
					fresh  = 1'b1;
				end
			end
			PH_OCT1, PH_OCT2: begin
				if (c >= CH_ZERO && c <= CH_SEVEN) begin
					if (ph_q == PH_OCT2) begin
						lst[n] = pv_oct;
						n      = n + 3'd1;
						pv_n   = '0;
						ph_n   = PH_IDLE;
					end else begin
						pv_n = pv_oct;
						ph_n = PH_OCT2;
					end
				end else begin
					lst[n] = pv_q;
					n      = n + 3'd1;
					pv_n   = '0;
					ph_n   = PH_IDLE;
					fresh  = 1'b1;
				end
			end
			PH_HEX, PH_UNI: begin
				if (hv[4]) begin
					if (need_done) begin
						lst[n] = pv_hex;
						n      = n + 3'd1;
						pv_n   = '0;
						hc_n   = '0;
						ph_n   = PH_IDLE;
					end else begin
						held_n[hc_q] = c[HOLD_W-1:0];
						hc_n         = hc_q + 2'd1;
						pv_n         = pv_hex;
					end
				end else begin
					// failed escape: letter, then the held digits as text
					lst[n] = letter;
					n      = n + 3'd1;
					for (int k = 0; k < HOLD_DEPTH; k++) begin
						if (k < int'(hc_q)) begin
							lst[n] = {{(CHAR_W-HOLD_W){1'b0}}, held_q[k]};
							n      = n + 3'd1;
						end
					end
					pv_n  = '0;
					hc_n  = '0;
					ph_n  = PH_IDLE;
					fresh = 1'b1;
				end
			end
			default: begin
				ph_n  = PH_IDLE;
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			if (c == CH_BSLASH) begin
				ph_n = PH_BS;
			end else begin
				lst[n] = c;
				n      = n + 3'd1;
			end
		end

		// end of text flushes whatever escape is still open
		if (in_last) begin
			f_letter = (ph_n == PH_UNI) ? CH_U : CH_X;
			case (ph_n)
				PH_BS: begin lst[n] = CH_BSLASH; n = n + 3'd1; end
				PH_OCT0: begin lst[n] = '0; n = n + 3'd1; end
				PH_OCT1, PH_OCT2: begin lst[n] = pv_n; n = n + 3'd1; end
				PH_HEX, PH_UNI: begin
					lst[n] = f_letter;
					n      = n + 3'd1;
					for (int k = 0; k < HOLD_DEPTH; k++) begin
						if (k < int'(hc_n)) begin
							lst[n] = {{(CHAR_W-HOLD_W){1'b0}}, held_n[k]};
							n      = n + 3'd1;
						end
					end
				end
				default: ;
			endcase
			ph_n = PH_IDLE;
			hc_n = '0;
			pv_n = '0;
		end

		for (int k = 0; k < RES_DEPTH; k++) begin
			lst[k] = lst[k] & CHAR_MASK;
		end
	end

	assign stat.load_has_res = (n != '0);
	assign stat.one_left     = (cnt_q == RES_CNT_W'(1));

	assign out_char = buf_q[0];
	assign run_last = (cnt_q == RES_CNT_W'(1));
	assign text_end = run_last & end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			pv_q  <= '0;
			hc_q  <= '0;
			cnt_q <= '0;
			end_q <= 1'b0;
		end else if (cmd.load) begin
			ph_q  <= ph_n;
			pv_q  <= pv_n;
			hc_q  <= hc_n;
			cnt_q <= n;
			end_q <= in_last;
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			held_q <= held_n;
			buf_q  <= lst;
		end else if (cmd.pop) begin
			for (int k = 0; k < RES_DEPTH - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

endmodule

@@ design/escape_sequence_decoder_top.sv @@
// top level of the backslash escape decoder for a 16-bit character stream
//
// Decodes C-style backslash escapes: \0 with up to three octal digits (first 0-3), \xHH,
// \uHHHH, \a \b \f \n \r \t \v, a doubled backslash, and any other escaped character as
// itself. Each input beat carries one character and a last-of-text flag; the beat is
// decoded in the cycle it is accepted and its zero to five result characters go into a
// five-entry result buffer, which drains one output beat per cycle while m_axis_tready
// is high. An input beat that yields no character (a backslash, or a digit held inside
// an escape) leaves the slave side ready; after one that yields characters the slave
// side waits until the buffer has drained through the single output port. A failed hex
// or unicode escape replays the letter and the held digits as one burst, then the
// breaking character. tlast on the output marks the last character caused by one input
// beat, and tuser the final character of the whole text; at end of text any open escape
// is flushed and the decoder returns to idle. There are no configuration registers.
module escape_sequence_decoder_top import esd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] in_char
	input  logic        s_axis_tlast,  // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] out_char
	output logic        m_axis_tlast,  // run_last
	output logic        m_axis_tuser   // [0] text_end
);

	esd_cmd_t  cmd;
	esd_stat_t stat;

	// handshake and sequencing of load and drain
	esd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// escape decoding and the result buffer
	esd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.stat     (stat),
		.out_char (m_axis_tdata),
		.run_last (m_axis_tlast),
		.text_end (m_axis_tuser)
	);

endmodule

@@ design/esd_checker.sv @@
// port-level checks for the escape decoder, bound to the top level
module esd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// no new beat is taken while results are still draining
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while results pending");

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled output beat changed");

	// end of text is always the last beat of its run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("text end without run end");

	// after the last beat of a run the block returns to taking input
	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
		else $error("output continued past run end");

endmodule

bind escape_sequence_decoder_top esd_checker u_esd_checker (.*);

@@ sim/tb.sv @@
// testbench for the escape sequence decoder: directed and random text checked against a predictor
`timescale 1ns / 1ps

module tb;
	import esd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500_000;
	localparam int unsigned RANDOM_BEATS = 300;
	localparam int unsigned SETTLE       = 20;

	// characters the package does not name
	localparam logic [15:0] CH_NINE  = 16'h0039;
	localparam logic [15:0] CH_CAP_A = 16'h0041;
	localparam logic [15:0] CH_CAP_F = 16'h0046;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [15:0] in_char
	logic        s_axis_tlast;  // in_last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // [15:0] out_char
	logic        m_axis_tlast;  // run_last
	logic        m_axis_tuser;  // [0] text_end

	// one decoded character as it should leave the block
	typedef struct packed {
		logic [15:0] ch;
		logic        run_end;
		logic        text_done;
	} dec_char_t;

	dec_char_t   want_q[$];
	logic [15:0] burst[$];

	// predictor state
	phase_t      esc_phase;
	logic [15:0] held_q[3];
	int unsigned held_n;
	logic [15:0] accum;

	int unsigned errors;
	int unsigned beats_sent;
	int unsigned cycles;
	bit          tx_quiet;
	bit          rx_quiet;
	int unsigned stall_left;

	escape_sequence_decoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic void put(input logic [15:0] v);
		if (burst.size() < RES_DEPTH) begin
			burst.push_back(v & CHAR_MASK);
		end
	endfunction

	// -1 when not a hex digit
	function automatic int nibble_of(input logic [15:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_A && c <= CH_F) return int'(c - CH_A) + 10;
		if (c >= CH_CAP_A && c <= CH_CAP_F) return int'(c - CH_CAP_A) + 10;
		return -1;
	endfunction

	function automatic void fresh(input logic [15:0] c);
		if (c == CH_BSLASH) begin
			esc_phase = PH_BS;
		end else begin
			put(c);
		end
	endfunction

	// failed hex or unicode escape: letter, then held digits as they came
	function automatic void give_up_hex(input logic [15:0] letter);
		put(letter);
		for (int k = 0; k < held_n; k++) put(held_q[k]);
		held_n    = 0;
		accum     = '0;
		esc_phase = PH_IDLE;
	endfunction

	function automatic void hex_digit(input logic [15:0] c, input logic [15:0] letter,
		input int unsigned need);
		int h;
		h = nibble_of(c);
		if (h < 0) begin
			give_up_hex(letter);
			fresh(c);
		end else begin
			accum = {accum[11:0], 4'(h)};
			if (held_n + 1 >= need) begin
				put(accum);
				held_n    = 0;
				accum     = '0;
				esc_phase = PH_IDLE;
			end else begin
				held_q[held_n] = c;
				held_n++;
			end
		end
	endfunction

	function automatic void end_octal();
		put(accum);
		accum     = '0;
		esc_phase = PH_IDLE;
	endfunction

	function automatic void decode_step(input logic [15:0] c);
		case (esc_phase)
			PH_BS: begin
				esc_phase = PH_IDLE;
				accum     = '0;
				held_n    = 0;
				case (c)
					CH_ZERO: esc_phase = PH_OCT0;
					CH_X:    esc_phase = PH_HEX;
					CH_U:    esc_phase = PH_UNI;
					CH_A:    put(CODE_BEL);
					CH_B:    put(CODE_BS);
					CH_F:    put(CODE_FF);
					CH_N:    put(CODE_LF);
					CH_R:    put(CODE_CR);
					CH_T:    put(CODE_HT);
					CH_V:    put(CODE_VT);
					default: put(c);
				endcase
			end
			PH_OCT0: begin
				if (c >= CH_ZERO && c <= CH_THREE) begin
					accum     = c - CH_ZERO;
					esc_phase = PH_OCT1;
				end else begin
					accum = '0;
					end_octal();
					fresh(c);
				end
			end
			PH_OCT1, PH_OCT2: begin
				if (c >= CH_ZERO && c <= CH_SEVEN) begin
					accum = {accum[12:0], 3'b000} + (c - CH_ZERO);
					if (esc_phase == PH_OCT2) begin
						end_octal();
					end else begin
						esc_phase = PH_OCT2;
					end
				end else begin
					end_octal();
					fresh(c);
				end
			end
			PH_HEX:  hex_digit(c, CH_X, 2);
			PH_UNI:  hex_digit(c, CH_U, 4);
			default: begin
				esc_phase = PH_IDLE;
				fresh(c);
			end
		endcase
	endfunction

	// end of text flushes whatever escape is open
	function automatic void close_text();
		case (esc_phase)
			PH_BS:            put(CH_BSLASH);
			PH_OCT0:          put('0);
			PH_OCT1, PH_OCT2: put(accum);
			PH_HEX:           give_up_hex(CH_X);
			PH_UNI:           give_up_hex(CH_U);
			default:          ;
		endcase
		esc_phase = PH_IDLE;
		held_n    = 0;
		accum     = '0;
	endfunction

	function automatic void predict_beat(input logic [15:0] c, input logic last);
		dec_char_t e;
		burst.delete();
		decode_step(c & CHAR_MASK);
		if (last) close_text();
		foreach (burst[i]) begin
			e.ch        = burst[i];
			e.run_end   = (i == burst.size() - 1);
			e.text_done = e.run_end && last;
			want_q.push_back(e);
		end
	endfunction

	// ---------------- monitor and checker ----------------

	// both sides sampled at the edge, input beat predicted before output beat is checked
	always @(posedge clk) begin : watch_beats
		dec_char_t exp_c;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_beat(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_q.size() == 0) begin
					$error("unexpected beat: out_char %h run_last %b text_end %b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
					errors++;
				end else begin
					exp_c = want_q.pop_front();
					if (exp_c.ch !== m_axis_tdata) begin
						$error("out_char: expected %h, got %h", exp_c.ch, m_axis_tdata);
						errors++;
					end
					if (exp_c.run_end !== m_axis_tlast) begin
						$error("run_last: expected %b, got %b", exp_c.run_end, m_axis_tlast);
						errors++;
					end
					if (exp_c.text_done !== m_axis_tuser) begin
						$error("text_end: expected %b, got %b", exp_c.text_done, m_axis_tuser);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------- idling ----------------

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left = pick_gap(1'b0);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ---------------- stimulus ----------------

	// valid stays up between back-to-back beats
	task automatic send_item(input logic [15:0] c, input bit last);
		int unsigned gap;
		gap = pick_gap(tx_quiet);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++) begin
			send_item({8'h00, s[i]}, last_at_end && (i == s.len() - 1));
		end
	endtask

	function automatic logic [15:0] random_char();
		if ($urandom_range(0, 1) == 0) return 16'($urandom());
		return 16'($urandom_range(16'h0020, 16'h007E));
	endfunction

	function automatic logic [15:0] random_hex();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return {8'h00, digits[$urandom_range(0, 21)]};
	endfunction

	function automatic bit random_last();
		return $urandom_range(0, 15) == 0;
	endfunction

	task automatic test_plain_extremes();
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0000, 1'b1);
	endtask

	// newline, doubled backslash, and an unknown letter that passes through
	task automatic test_simple_escapes();
		send_text("\\n\\\\\\q", 1'b0);
	endtask

	// full octal, first digit above 3 cuts it short, backslash-0 right at end of text
	task automatic test_octal();
		send_text("\\0377\\05", 1'b0);
		send_text("\\0", 1'b1);
	endtask

	// full hex, hex cut by end of text, unicode cut by a non-hex character
	task automatic test_hex_unicode();
		send_text("\\xAf", 1'b0);
		send_text("\\x7", 1'b1);
		send_text("\\u12g", 1'b0);
	endtask

	// lone backslash at end, then the longest burst: u, three digits, backslash
	task automatic test_end_of_text();
		send_text("\\", 1'b1);
		send_text("\\u123\\", 1'b1);
	endtask

	task automatic test_random_text();
		int unsigned stop_at;
		int unsigned kind;
		int unsigned n;
		int unsigned need;
		string       letters;
		letters = "abfnrtv\\";
		stop_at = beats_sent + RANDOM_BEATS;
		while (beats_sent < stop_at) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1: send_item(random_char(), random_last());
				2: begin
					send_item(CH_BSLASH, random_last());
					if ($urandom_range(0, 8) == 0) begin
						send_item(random_char(), random_last());
					end else begin
						send_item({8'h00, letters[$urandom_range(0, 7)]}, random_last());
					end
				end
				3: begin
					// well-formed octal with zero to three digits
					send_item(CH_BSLASH, random_last());
					send_item(CH_ZERO, random_last());
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++) begin
						send_item(CH_ZERO + 16'($urandom_range(0, i == 0 ? 3 : 7)),
							random_last());
					end
				end
				4, 5, 6, 7: begin
					// well-formed hex or unicode
					need = (kind < 6) ? 2 : 4;
					send_item(CH_BSLASH, random_last());
					send_item((kind < 6) ? CH_X : CH_U, random_last());
					for (int i = 0; i < need; i++) send_item(random_hex(), random_last());
				end
				8: begin
					// hex or unicode broken after some digits
					need = $urandom_range(0, 1) ? 2 : 4;
					n = $urandom_range(0, need - 1);
					send_item(CH_BSLASH, random_last());
					send_item((need == 2) ? CH_X : CH_U, random_last());
					for (int i = 0; i < n; i++) send_item(random_hex(), random_last());
					send_item(($urandom_range(0, 3) == 0) ? CH_BSLASH : random_char(),
						random_last());
				end
				default: begin
					// octal broken by a high first digit or a stray character
					send_item(CH_BSLASH, random_last());
					send_item(CH_ZERO, random_last());
					if ($urandom_range(0, 1) == 0) begin
						send_item(CH_ZERO + 16'($urandom_range(4, 9)), random_last());
					end else begin
						send_item(random_char(), random_last());
					end
				end
			endcase
		end
		// close the text so nothing stays open
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		send_item(random_char(), 1'b1);
	endtask

	task automatic finish_run();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (want_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		tx_quiet      = 1'b0;
		rx_quiet      = 1'b0;
		stall_left    = 0;
		errors        = 0;
		beats_sent    = 0;
		cycles        = 0;
		esc_phase     = PH_IDLE;
		held_n        = 0;
		accum         = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_plain_extremes();
		test_simple_escapes();
		test_octal();
		test_hex_unicode();
		test_end_of_text();
		test_random_text();
		finish_run();
	end

endmodule
